// ===== sv/lbcd_pkg.sv =====
// shared types and constants for the lru block cache directory
`timescale 1ns / 1ps
package lbcd_pkg;
    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic       CMD_GET = 1'b0;
    localparam logic       CMD_PUT = 1'b1;
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_GET_MISS = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    typedef struct packed {
        logic        command;
        logic [63:0] node_id;
        logic [63:0] block_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  slot;
        logic        evicted;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear scan results
        logic scan_clr;  // reset scan index
        logic scan_step; // examine one entry, advance index
        logic upd_step;  // update one entry's rank, advance index
        logic touch;     // hit: decrement ranks above hit rank
        logic evict;     // evict: decrement all nonzero, clear victim
        logic finish;    // write mru rank / insert, build result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic hit;
        logic full;
        logic put;
    } t_sts;
endpackage

// ===== sv/lbcd_datapath.sv =====
// tag and rank storage with serial scan and update
`timescale 1ns / 1ps
module lbcd_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lbcd_pkg::t_req  i_req,
    input  lbcd_pkg::t_cmd  i_cmd,
    output lbcd_pkg::t_sts  o_sts,
    output lbcd_pkg::t_rsp  o_rsp
);
    import lbcd_pkg::*;

    logic [63:0]        r_node_mem [ENTRIES];
    logic [63:0]        r_block_mem[ENTRIES];
    logic [IDX_W-1:0]   r_rank     [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    t_req             r_req;
    logic [IDX_W:0]   r_idx;
    logic             r_hit, r_free_found;
    logic [IDX_W-1:0] r_hit_slot, r_free_slot, r_vic_slot, r_hit_rank;
    logic [CNT_W-1:0] r_count;
    logic             r_ev;
    logic [31:0]      r_hits, r_misses;
    t_rsp             r_rsp, n_rsp;

    // registered memory read data, one index behind r_idx
    logic [63:0]      r_node_rd, r_block_rd;
    logic [IDX_W-1:0] r_rank_rd;
    logic             r_cmp_v;
    logic [IDX_W-1:0] r_cmp_i;
    logic             r_upd_v, r_upd_touch, r_upd_evict;
    logic [IDX_W-1:0] r_upd_i;

    logic [IDX_W-1:0] w_i;
    logic             w_match;
    logic             w_full;
    logic             w_key_ok;
    logic             w_ins;
    logic [IDX_W-1:0] w_ins_slot;
    logic             w_evict_wb;
    logic             w_rank_we;
    logic [IDX_W-1:0] w_rank_wa, w_rank_wd;

    assign w_i        = r_idx[IDX_W-1:0];
    assign w_full     = (r_count == CNT_W'(ENTRIES));
    assign w_key_ok   = (r_req.node_id != 64'd0) && (r_req.block_id != 64'd0);
    assign w_match    = r_cmp_v && r_valid[r_cmp_i] && r_node_rd == r_req.node_id
                        && r_block_rd == r_req.block_id;
    assign w_ins_slot = r_ev ? r_vic_slot : r_free_slot;
    assign w_ins      = i_cmd.finish && !r_hit && (r_req.command == CMD_PUT) && w_key_ok
                        && (r_ev || r_free_found);
    assign w_evict_wb = r_upd_v && r_upd_evict && r_valid[r_upd_i]
                        && (r_upd_i == r_vic_slot);

    // one rank write per cycle: update write-back, or the mru / insert rank
    always_comb begin
        w_rank_we = 1'b0;
        w_rank_wa = r_upd_i;
        w_rank_wd = r_rank_rd - 1'b1;
        if (r_upd_v && r_valid[r_upd_i]) begin
            if (r_upd_touch && r_rank_rd > r_hit_rank) begin
                w_rank_we = 1'b1;
            end
            if (r_upd_evict) begin
                if (r_upd_i == r_vic_slot) begin
                    w_rank_we = 1'b1;
                    w_rank_wd = '0;
                end else if (r_rank_rd != '0) begin
                    w_rank_we = 1'b1;
                end
            end
        end
        if (i_cmd.finish && r_hit) begin
            w_rank_we = 1'b1;
            w_rank_wa = r_hit_slot;
            w_rank_wd = IDX_W'(r_count - 1'b1);
        end else if (w_ins) begin
            w_rank_we = 1'b1;
            w_rank_wa = w_ins_slot;
            w_rank_wd = IDX_W'(r_count);
        end
    end

    always_comb begin
        n_rsp            = '0;
        n_rsp.hit_count  = r_hits;
        n_rsp.miss_count = r_misses + 1'b1;
        if (r_hit) begin
            n_rsp.status     = ST_HIT;
            n_rsp.slot       = 7'(r_hit_slot);
            n_rsp.hit_count  = r_hits + 1'b1;
            n_rsp.miss_count = r_misses;
        end else if (r_req.command == CMD_GET) begin
            n_rsp.status = ST_GET_MISS;
        end else begin
            n_rsp.evicted = r_ev;
            if (r_ev) begin
                n_rsp.slot = 7'(r_vic_slot);
            end
            if (w_key_ok) begin
                n_rsp.status = ST_INSERTED;
                n_rsp.slot   = 7'(w_ins_slot);
            end else begin
                n_rsp.status = ST_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_node_mem[w_ins_slot]  <= r_req.node_id;
            r_block_mem[w_ins_slot] <= r_req.block_id;
        end
        if (w_rank_we) begin
            r_rank[w_rank_wa] <= w_rank_wd;
        end
        r_node_rd  <= r_node_mem[w_i];
        r_block_rd <= r_block_mem[w_i];
        r_rank_rd  <= r_rank[w_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_idx    <= '0;
            r_cmp_v  <= 1'b0;
            r_upd_v  <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_cmp_v     <= i_cmd.scan_step && (r_idx < (IDX_W+1)'(ENTRIES));
            r_cmp_i     <= w_i;
            r_upd_v     <= i_cmd.upd_step;
            r_upd_i     <= w_i;
            r_upd_touch <= i_cmd.touch;
            r_upd_evict <= i_cmd.evict;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step || i_cmd.upd_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_req        <= i_req;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_ev         <= 1'b0;
            end else begin
                if (r_cmp_v) begin
                    if (!r_valid[r_cmp_i] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_slot  <= r_cmp_i;
                    end
                    if (r_valid[r_cmp_i] && r_rank_rd == '0) begin
                        r_vic_slot <= r_cmp_i;
                    end
                    if (w_match && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_cmp_i;
                        r_hit_rank <= r_rank_rd;
                    end
                end
                if (w_evict_wb) begin
                    r_ev <= 1'b1;
                end
            end
            if (w_evict_wb) begin
                r_valid[r_upd_i] <= 1'b0;
            end else if (w_ins) begin
                r_valid[w_ins_slot] <= 1'b1;
            end
            if (i_cmd.evict && !i_cmd.upd_step) begin
                r_count <= r_count - 1'b1;
            end else if (w_ins) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.finish) begin
                r_rsp    <= n_rsp;
                r_hits   <= n_rsp.hit_count;
                r_misses <= n_rsp.miss_count;
            end
        end
    end

    assign o_sts.scan_last = (r_idx == (IDX_W+1)'(ENTRIES));
    assign o_sts.hit       = r_hit;
    assign o_sts.full      = w_full;
    assign o_sts.put       = (r_req.command == CMD_PUT);
    assign o_rsp           = r_rsp;
endmodule

// ===== sv/lbcd_ctrl.sv =====
// request sequencer for the directory datapath
`timescale 1ns / 1ps
module lbcd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lbcd_pkg::t_sts i_sts,
    output lbcd_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import lbcd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_UPD    = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_evict, n_evict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_evict <= 1'b0;
        end else begin
            r_state <= n_state;
            r_evict <= n_evict;
        end
    end

    always_comb begin
        n_state = r_state;
        n_evict = r_evict;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.scan_step = 1'b1;
                n_state         = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.scan_clr = 1'b1;
                n_evict        = !i_sts.hit && i_sts.put && i_sts.full;
                if (i_sts.hit || n_evict) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_UPD: begin
                o_cmd.upd_step = 1'b1;
                o_cmd.touch    = !r_evict;
                o_cmd.evict    = r_evict;
                if (i_sts.scan_last) begin
                    o_cmd.upd_step = 1'b0;
                    o_cmd.touch    = 1'b0;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_evict      = 1'b0;
                n_state      = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);
endmodule

// ===== sv/lru_block_cache_directory.sv =====
// top level of the lru block cache directory
//   channel  | signals                  | handshake
//   request  | start, i_req, busy       | taken when start && !busy
//   result   | o_done, o_rsp            | one-cycle strobe, no back-pressure
// a hit or an eviction runs a serial tag scan, then a serial rank update, one slot
// per cycle; other misses skip the rank update
// busy drops the cycle after the strobe, and a new word can be taken once it is low
// reset is synchronous, active low, and clears valid bits and counters.
// the receiver cannot stall; busy holds off new words until the result is out
`timescale 1ns / 1ps
module lru_block_cache_directory (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lbcd_pkg::t_req i_req,
    output logic           o_done,
    output lbcd_pkg::t_rsp o_rsp
);
    import lbcd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lbcd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    lbcd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== tb/sv/lru_block_cache_directory_test.sv =====
// testbench for the lru block cache directory: lru predictor, random get/put traffic
`timescale 1ns / 1ps
module lru_block_cache_directory_test;
    import lbcd_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int N_RANDOM     = 1430;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_req   i_req = '0;
    logic   o_done;
    t_rsp   o_rsp;

    lru_block_cache_directory dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic              dir_valid [ENTRIES];
    logic [63:0]       dir_node  [ENTRIES];
    logic [63:0]       dir_block [ENTRIES];
    int unsigned       dir_rank  [ENTRIES];
    logic [31:0]       hits_seen;
    logic [31:0]       misses_seen;

    t_req   pending_words [$];
    t_rsp   expected_rsps [$];
    int     errors = 0;
    int     cycles = 0;
    bit     stim_done = 1'b0;
    bit     quiet_phase = 1'b0;
    int     drv_gap = 0;

    function automatic int unsigned occupied();
        int unsigned n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) if (dir_valid[i]) n++;
        return n;
    endfunction

    function automatic t_rsp lookup_and_update(t_req rq);
        t_rsp        r;
        int          hs;
        int unsigned n;
        int unsigned rk;
        int          victim;
        int          f;
        r = '0;
        hs = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hs < 0 && dir_valid[i] && dir_node[i] == rq.node_id
                && dir_block[i] == rq.block_id) hs = i;
        if (hs >= 0) begin
            n = occupied();
            rk = dir_rank[hs];
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i] && dir_rank[i] > rk) dir_rank[i]--;
            dir_rank[hs] = n - 1;
            hits_seen++;
            r.status = ST_HIT;
            r.slot = hs[6:0];
        end else begin
            misses_seen++;
            if (rq.command == CMD_GET) begin
                r.status = ST_GET_MISS;
            end else begin
                n = occupied();
                if (n >= ENTRIES) begin
                    victim = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (dir_valid[i] && (victim < 0 || dir_rank[i] < dir_rank[victim]))
                            victim = i;
                    for (int i = 0; i < ENTRIES; i++)
                        if (dir_valid[i] && i != victim && dir_rank[i] > 0) dir_rank[i]--;
                    dir_valid[victim] = 1'b0;
                    dir_rank[victim] = 0;
                    r.slot = victim[6:0];
                    r.evicted = 1'b1;
                    n = occupied();
                end
                if (rq.node_id == 64'd0 || rq.block_id == 64'd0) begin
                    r.status = ST_INVALID;
                end else begin
                    f = 0;
                    while (f < ENTRIES && dir_valid[f]) f++;
                    if (f < ENTRIES) begin
                        dir_valid[f] = 1'b1;
                        dir_node[f] = rq.node_id;
                        dir_block[f] = rq.block_id;
                        dir_rank[f] = n;
                    end
                    r.status = ST_INSERTED;
                    r.slot = f[6:0];
                end
            end
        end
        r.hit_count = hits_seen;
        r.miss_count = misses_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    // driver: start is raised only while busy is low, so it is taken at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (busy) begin
                start <= 1'b0;
            end else if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                start   <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_req <= pending_words.pop_front();
                start <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    drv_gap <= $urandom_range(1, 17);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp want;
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy)
            expected_rsps.push_back(lookup_and_update(i_req));
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_rsp.status), 64'd0);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", 64'(o_rsp.status), 64'(want.status));
                if (o_rsp.slot !== want.slot)
                    report_mismatch("slot", 64'(o_rsp.slot), 64'(want.slot));
                if (o_rsp.evicted !== want.evicted)
                    report_mismatch("evicted", 64'(o_rsp.evicted), 64'(want.evicted));
                if (o_rsp.hit_count !== want.hit_count)
                    report_mismatch("hit_count", 64'(o_rsp.hit_count),
                                    64'(want.hit_count));
                if (o_rsp.miss_count !== want.miss_count)
                    report_mismatch("miss_count", 64'(o_rsp.miss_count),
                                    64'(want.miss_count));
            end
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_req make_word(logic cmd, logic [63:0] nd, logic [63:0] bk);
        t_req w;
        w.command = cmd;
        w.node_id = nd;
        w.block_id = bk;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] nd;
        logic [63:0] bk;
        int          pool;
        int          sel;
        for (int i = 0; i < ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_node[i] = '0;
            dir_block[i] = '0;
            dir_rank[i] = 0;
        end
        hits_seen = '0;
        misses_seen = '0;

        // directed: empty miss, inserts, hits, invalid keys, extremes
        pending_words.push_back(make_word(CMD_GET, 64'd1, 64'd1));
        pending_words.push_back(make_word(CMD_PUT, 64'd1, 64'd1));
        pending_words.push_back(make_word(CMD_GET, 64'd1, 64'd1));
        pending_words.push_back(make_word(CMD_PUT, 64'd1, 64'd1));
        pending_words.push_back(make_word(CMD_PUT, '1, '1));
        pending_words.push_back(make_word(CMD_GET, '1, '1));
        pending_words.push_back(make_word(CMD_PUT, 64'd0, 64'd5));
        pending_words.push_back(make_word(CMD_PUT, 64'd5, 64'd0));
        pending_words.push_back(make_word(CMD_PUT, 64'd0, 64'd0));
        pending_words.push_back(make_word(CMD_GET, 64'd0, 64'd0));
        pending_words.push_back(make_word(CMD_PUT, 64'h5555_5555_5555_5555,
                                          64'hAAAA_AAAA_AAAA_AAAA));
        pending_words.push_back(make_word(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA,
                                          64'h5555_5555_5555_5555));
        pending_words.push_back(make_word(CMD_GET, 64'd1, 64'd1));
        pending_words.push_back(make_word(CMD_GET, 64'h8000_0000_0000_0000, 64'd1));

        // random: small key pool so the cache fills, hits and evicts often
        for (int k = 0; k < N_RANDOM; k++) begin
            pool = (k < 700) ? 160 : 200;
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                nd = rand64();
                bk = rand64();
            end else if (sel == 1) begin
                nd = ($urandom_range(0, 1) != 0) ? 64'd0 : rand64();
                bk = (nd == 64'd0 && $urandom_range(0, 1) != 0) ? rand64() : 64'd0;
            end else begin
                nd = 64'd1 + $urandom_range(0, pool - 1);
                bk = {nd[31:0] ^ 32'hDEAD_BEEF, 32'h0000_1000} + nd;
            end
            pending_words.push_back(make_word($urandom_range(0, 2) != 0 ? CMD_PUT : CMD_GET,
                                              nd, bk));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_words.size() < 150);
        quiet_phase = 1'b1;
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        while (start || expected_rsps.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
